FILE: src/acdsc_pkg.sv
// shared types, constants and register codes for the audio drift correction block
`timescale 1ns / 1ps
`default_nettype none

package acdsc_pkg;

    localparam int unsigned WARM_W  = 6;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 25;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    // frames averaged before any correction is applied
    localparam logic [WARM_W-1:0] AVG_WARMUP = 6'd20;

    // ceil(2^31 / 100): floor(x / 100) = (x * RECIP_100) >> 31 for x below 2^24
    localparam logic [MUL_B_W-1:0] RECIP_100 = 25'd21474837;
    localparam int unsigned        RECIP_SH  = 31;

    localparam logic [6:0] PCT_MAX = 7'd100;

    // register indexes on the configuration port
    localparam logic [2:0] REG_SYNC_TO_AUDIO      = 3'd0;
    localparam logic [2:0] REG_AVG_COEF           = 3'd1;
    localparam logic [2:0] REG_DIFF_THRESHOLD     = 3'd2;
    localparam logic [2:0] REG_NOSYNC_LIMIT       = 3'd3;
    localparam logic [2:0] REG_CORRECTION_PERCENT = 3'd4;
    localparam logic [2:0] REG_SOURCE_RATE        = 3'd5;

    // register reset values
    localparam logic [15:0] RST_AVG_COEF           = 16'd52057;
    localparam logic [30:0] RST_DIFF_THRESHOLD     = 31'd1677722;
    localparam logic [30:0] RST_NOSYNC_LIMIT       = 31'd167772160;
    localparam logic [6:0]  RST_CORRECTION_PERCENT = 7'd10;
    localparam logic [17:0] RST_SOURCE_RATE        = 18'd44100;

    typedef struct packed {
        logic        sync_to_audio;
        logic [15:0] avg_coef;
        logic [30:0] diff_threshold;
        logic [30:0] nosync_limit;
        logic [6:0]  correction_percent;
        logic [17:0] source_rate;
    } cfg_t;

    typedef struct packed {
        logic [15:0] nominal_samples;
        logic [31:0] clock_diff;
        logic        diff_valid;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MHI,
        S_SUM,
        S_SAT,
        S_ABS,
        S_AHI,
        S_ACMP,
        S_TEST,
        S_RATE,
        S_LOX,
        S_LOD,
        S_HIX,
        S_HID,
        S_OUT
    } seq_state_t;

endpackage

`default_nettype wire

FILE: src/acdsc_mul.sv
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module acdsc_mul
    import acdsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic      [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: src/acdsc_seq.sv
// sequencer, datapath and drift state around the shared multiplier
`timescale 1ns / 1ps
`default_nettype none

module acdsc_seq
    import acdsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        start,
    input  wire item_t       item,
    input  wire logic        out_free,
    output logic             idle,
    output logic             done,
    output logic [16:0]      wanted
);

    seq_state_t state_reg, state_next;

    logic [15:0]        nb_reg;
    logic [31:0]        diff_reg;
    logic               valid_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [WARM_W-1:0]  warm_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        t_reg;
    logic [27:0]        raw_reg;
    logic [16:0]        lo_reg;
    logic [16:0]        wanted_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    logic [6:0]         pct;
    logic [7:0]         pct_lo_mul;
    logic [7:0]         pct_hi_mul;
    logic [31:0]        diff_mag;
    logic               diff_ok;
    logic [SUM_W-1:0]   sum_off;
    logic [SUM_W-1:0]   sum_mag;
    logic [16:0]        coef_f;
    logic [SUM_W-1:0]   scaled;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               avg_hit;
    logic [25:0]        delta_mag;
    logic [27:0]        delta;
    logic [16:0]        hi_val;
    logic [16:0]        clipped;

    acdsc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign pct        = (cfg.correction_percent > PCT_MAX) ? PCT_MAX : cfg.correction_percent;
    assign pct_lo_mul = {1'b0, PCT_MAX - pct};
    assign pct_hi_mul = {1'b0, PCT_MAX} + {1'b0, pct};

    assign diff_mag = diff_reg[31] ? (32'd0 - diff_reg) : diff_reg;
    assign diff_ok  = valid_reg && ({1'b0, diff_mag} < {2'b00, cfg.nosync_limit});

    // sum offset by 2^47 so both halves multiply as unsigned
    assign sum_off = {~sum_reg[SUM_W-1], sum_reg[SUM_W-2:0]};
    assign sum_mag = sum_reg[SUM_W-1] ? (48'd0 - sum_reg) : sum_reg;
    assign coef_f  = 17'h10000 - {1'b0, cfg.avg_coef};

    // floor((coef * sum + 2^15) / 2^16) sits in the upper bits of t_reg
    assign scaled   = t_reg[63:16];
    assign sum_wide = {{17{diff_reg[31]}}, diff_reg} + {scaled[SUM_W-1], scaled};
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    assign avg_hit = t_reg >= {17'd0, cfg.diff_threshold, 16'd0};

    // trunc toward zero: scale the magnitude, then restore the sign
    assign delta_mag = prod[49:24];
    assign delta     = diff_reg[31] ? (28'd0 - {2'b00, delta_mag}) : {2'b00, delta_mag};

    assign hi_val = prod[RECIP_SH+16:RECIP_SH];

    always_comb
    begin
        priority if ($signed(raw_reg) < $signed({11'd0, lo_reg}))
            clipped = lo_reg;
        else if ($signed(raw_reg) > $signed({11'd0, hi_val}))
            clipped = hi_val;
        else
            clipped = raw_reg[16:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_CHECK;
            S_CHECK: state_next = (cfg.sync_to_audio || !diff_ok) ? S_OUT : S_MHI;
            S_MHI:   state_next = S_SUM;
            S_SUM:   state_next = S_SAT;
            S_SAT:   state_next = (warm_reg < AVG_WARMUP) ? S_OUT : S_ABS;
            S_ABS:   state_next = S_AHI;
            S_AHI:   state_next = S_ACMP;
            S_ACMP:  state_next = S_TEST;
            S_TEST:  state_next = avg_hit ? S_RATE : S_OUT;
            S_RATE:  state_next = S_LOX;
            S_LOX:   state_next = S_LOD;
            S_LOD:   state_next = S_HIX;
            S_HIX:   state_next = S_HID;
            S_HID:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CHECK:
            begin
                mul_a = {8'd0, sum_off[23:0]};
                mul_b = {9'd0, cfg.avg_coef};
            end
            S_MHI:
            begin
                mul_a = {8'd0, sum_off[47:24]};
                mul_b = {9'd0, cfg.avg_coef};
            end
            S_ABS:
            begin
                mul_a = {8'd0, sum_mag[23:0]};
                mul_b = {8'd0, coef_f};
            end
            S_AHI:
            begin
                mul_a = {8'd0, sum_mag[47:24]};
                mul_b = {8'd0, coef_f};
            end
            S_TEST:
            begin
                mul_a = diff_mag;
                mul_b = {7'd0, cfg.source_rate};
            end
            S_RATE:
            begin
                mul_a = {16'd0, nb_reg};
                mul_b = {17'd0, pct_lo_mul};
            end
            S_LOX, S_HIX:
            begin
                mul_a = {8'd0, prod[23:0]};
                mul_b = RECIP_100;
            end
            S_LOD:
            begin
                mul_a = {16'd0, nb_reg};
                mul_b = {17'd0, pct_hi_mul};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            warm_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CHECK && !cfg.sync_to_audio && !diff_ok)
            begin
                sum_reg  <= '0;
                warm_reg <= '0;
            end
            else if (state_reg == S_SAT)
            begin
                sum_reg <= sum_sat;
                if (warm_reg < AVG_WARMUP)
                    warm_reg <= warm_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            nb_reg    <= item.nominal_samples;
            diff_reg  <= item.clock_diff;
            valid_reg <= item.diff_valid;
        end
        unique case (state_reg)
            S_CHECK: wanted_reg <= {1'b0, nb_reg};
            // coef * (sum + 2^47) - coef * 2^47 + 2^15, modulo 2^64
            S_MHI:   acc_reg <= {24'd0, prod[39:0]} + 64'h8000 - {1'b0, cfg.avg_coef, 47'd0};
            S_SUM:   t_reg <= acc_reg + {prod[39:0], 24'd0};
            S_AHI:   acc_reg <= {23'd0, prod[40:0]};
            S_ACMP:  t_reg <= acc_reg + {prod[39:0], 24'd0};
            S_RATE:  raw_reg <= {12'd0, nb_reg} + delta;
            S_LOD:   lo_reg <= prod[RECIP_SH+16:RECIP_SH];
            S_HID:   wanted_reg <= clipped;
            default: ;
        endcase
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_OUT) && out_free;
    assign wanted = wanted_reg;

    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg <= AVG_WARMUP)
        else $error("warm-up count beyond limit");

    a_sum_write: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(sum_reg) |-> ($past(state_reg) == S_CHECK || $past(state_reg) == S_SAT))
        else $error("drift sum changed outside update steps");

    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && cfg.sync_to_audio) |=> ($stable(sum_reg) && $stable(warm_reg)))
        else $error("audio master mode touched drift state");

    a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HID) |=> (wanted_reg >= lo_reg && wanted_reg <= {nb_reg, 1'b0}))
        else $error("corrected count outside clip window");

endmodule

`default_nettype wire

FILE: src/audio_clock_drift_sample_correction.sv
// top level: configuration registers, stream ports and result register
`timescale 1ns / 1ps
`default_nettype none

// Audio drift sample-count correction. Each transaction on the s_ side is one decoded audio
// frame (nominal sample count, signed Q8.24 audio-minus-master clock difference, and a
// flag in s_tuser that is 0 when the difference is not a number); each transaction on the
// m_ side is the sample count the resampler should aim for. A leaky sum of differences
// with decay avg_coef is kept; after 20 valid frames a large enough average moves the
// count by diff * source_rate, clipped to +/- correction_percent. The steps of an item run
// one after another through a single registered 32x25 multiplier that is used up to nine
// times per item; frames in audio master mode, with an invalid or out-of-range difference,
// in warm-up or with no correction due skip the later steps. The result register lets the
// next frame enter while a result waits. The user must write registers through cfg_we,
// cfg_addr and cfg_wdata only while the block is idle; the block does not enforce it.

module audio_clock_drift_sample_correction
    import acdsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // nominal_samples[15:0], clock_diff[47:16]
    input  wire logic        s_tuser,   // diff_valid

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // wanted_samples[16:0], zero fill above
);

    cfg_t        cfg_reg;
    item_t       item;
    logic        start;
    logic        idle;
    logic        done;
    logic        out_free;
    logic [16:0] wanted;
    logic        m_valid_reg;
    logic [16:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_to_audio      <= 1'b0;
            cfg_reg.avg_coef           <= RST_AVG_COEF;
            cfg_reg.diff_threshold     <= RST_DIFF_THRESHOLD;
            cfg_reg.nosync_limit       <= RST_NOSYNC_LIMIT;
            cfg_reg.correction_percent <= RST_CORRECTION_PERCENT;
            cfg_reg.source_rate        <= RST_SOURCE_RATE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SYNC_TO_AUDIO:      cfg_reg.sync_to_audio      <= cfg_wdata[0];
                REG_AVG_COEF:           cfg_reg.avg_coef           <= cfg_wdata[15:0];
                REG_DIFF_THRESHOLD:     cfg_reg.diff_threshold     <= cfg_wdata;
                REG_NOSYNC_LIMIT:       cfg_reg.nosync_limit       <= cfg_wdata;
                REG_CORRECTION_PERCENT: cfg_reg.correction_percent <= cfg_wdata[6:0];
                REG_SOURCE_RATE:        cfg_reg.source_rate        <= cfg_wdata[17:0];
                default:                ;
            endcase
        end
    end

    assign item.nominal_samples = s_tdata[15:0];
    assign item.clock_diff      = s_tdata[47:16];
    assign item.diff_valid      = s_tuser;

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_valid_reg || m_tready;

    acdsc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .item     (item),
        .out_free (out_free),
        .idle     (idle),
        .done     (done),
        .wanted   (wanted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (done)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            m_data_reg <= wanted;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

endmodule

`default_nettype wire

FILE: tb/sv/tb_audio_clock_drift_sample_correction.sv
// self-checking testbench for the audio clock drift sample correction block
`timescale 1ns / 1ps

module tb_audio_clock_drift_sample_correction;

    import acdsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 16;

    localparam logic signed [31:0] HALF_SEC = 32'sd8388608;
    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [30:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // nominal_samples[15:0], clock_diff[47:16]
    logic        s_tuser;   // diff_valid
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // wanted_samples[16:0], zero fill above

    // predictor state and its copy of the registers
    cfg_t        cfg_model;
    longint      pred_drift_sum;
    logic [5:0]  pred_warmup;
    logic [16:0] wanted_q[$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          stall_en    = 1'b1;
    logic [7:0]  hold_token  = 8'd0;
    logic [7:0]  hold_seen   = 8'd0;

    always #6 clk = ~clk;

    audio_clock_drift_sample_correction i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!stall_en || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [16:0] predict_wanted_samples(item_t fr);
        longint nb;
        longint diff;
        longint mag;
        longint coef;
        longint lim;
        longint acc;
        longint pct;
        longint lo;
        longint hi;
        longint wanted;
        logic signed [65:0] sum_w;
        logic signed [65:0] avg_scaled;
        logic signed [65:0] thr_scaled;
        nb     = fr.nominal_samples;
        diff   = longint'(signed'(fr.clock_diff));
        mag    = (diff < 0) ? -diff : diff;
        coef   = cfg_model.avg_coef;
        lim    = cfg_model.nosync_limit;
        wanted = nb;
        if (!cfg_model.sync_to_audio) begin
            if (fr.diff_valid && mag < lim) begin
                acc = diff + ((coef * pred_drift_sum + 64'sh8000) >>> 16);
                if (acc > SUM_MAX)
                    acc = SUM_MAX;
                if (acc < SUM_MIN)
                    acc = SUM_MIN;
                pred_drift_sum = acc;
                if (pred_warmup < AVG_WARMUP) begin
                    pred_warmup = pred_warmup + 6'd1;
                end
                else begin
                    sum_w      = pred_drift_sum;
                    avg_scaled = sum_w * (64'sd65536 - coef);
                    if (avg_scaled < 0)
                        avg_scaled = -avg_scaled;
                    thr_scaled = longint'(cfg_model.diff_threshold) <<< 16;
                    if (avg_scaled >= thr_scaled) begin
                        pct = cfg_model.correction_percent;
                        if (pct > 100)
                            pct = 100;
                        lo = nb * (100 - pct) / 100;
                        hi = nb * (100 + pct) / 100;
                        // signed division truncates toward zero
                        wanted = nb + (diff * longint'(cfg_model.source_rate)) / 64'sd16777216;
                        if (wanted < lo)
                            wanted = lo;
                        if (wanted > hi)
                            wanted = hi;
                    end
                end
            end
            else begin
                pred_drift_sum = 0;
                pred_warmup    = '0;
            end
        end
        return wanted[16:0];
    endfunction

    function automatic item_t make_frame(logic [15:0] n, logic [31:0] d, logic v);
        item_t fr;
        fr.nominal_samples = n;
        fr.clock_diff      = d;
        fr.diff_valid      = v;
        return fr;
    endfunction

    // steady drift around which a phase's well-formed frames scatter
    function automatic logic [31:0] random_drift_bias();
        logic [31:0] m;
        m = $urandom_range(0, 1 << $urandom_range(8, 28));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic item_t random_frame(logic [31:0] bias);
        int          r;
        logic [15:0] n;
        logic [31:0] noise;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0:       n = 16'd0;
            1:       n = 16'hFFFF;
            default: n = 16'($urandom);
        endcase
        noise = $urandom_range(0, 1 << $urandom_range(4, 24));
        if ($urandom_range(0, 1))
            noise = -noise;
        if (r < 78)
            return make_frame(n, bias + noise, 1'b1);
        else if (r < 88)
            return make_frame(n, $urandom, 1'b1);
        else if (r < 95)
            return make_frame(n, $urandom, 1'b0);
        else
            return make_frame(n, r[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 1'($urandom));
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.sync_to_audio = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 9) == 0)
            c.avg_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            c.avg_coef = 16'($urandom_range(30000, 65535));
        c.diff_threshold = 31'($urandom) >> $urandom_range(0, 30);
        if ($urandom_range(0, 6) == 0)
            c.nosync_limit = 31'($urandom) >> $urandom_range(0, 30);
        else
            c.nosync_limit = 31'($urandom_range(32'h7FFF_FFFF, 32'h0800_0000));
        if ($urandom_range(0, 9) == 0)
            c.correction_percent = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        else
            c.correction_percent = 7'($urandom_range(0, 100));
        case ($urandom_range(0, 9))
            0:       c.source_rate = 18'd0;
            1:       c.source_rate = 18'h3FFFF;
            2:       c.source_rate = 18'd8000;
            3:       c.source_rate = 18'd48000;
            4:       c.source_rate = 18'd192000;
            5:       c.source_rate = 18'd44100;
            default: c.source_rate = 18'($urandom_range(1, 192000));
        endcase
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_SYNC_TO_AUDIO:      cfg_model.sync_to_audio      = val[0];
            REG_AVG_COEF:           cfg_model.avg_coef           = val[15:0];
            REG_DIFF_THRESHOLD:     cfg_model.diff_threshold     = val[30:0];
            REG_NOSYNC_LIMIT:       cfg_model.nosync_limit       = val[30:0];
            REG_CORRECTION_PERCENT: cfg_model.correction_percent = val[6:0];
            REG_SOURCE_RATE:        cfg_model.source_rate        = val[17:0];
            default: ;
        endcase
    endtask

    task automatic program_config(cfg_t c);
        write_reg(REG_SYNC_TO_AUDIO, 31'(c.sync_to_audio));
        write_reg(REG_AVG_COEF, 31'(c.avg_coef));
        write_reg(REG_DIFF_THRESHOLD, c.diff_threshold);
        write_reg(REG_NOSYNC_LIMIT, c.nosync_limit);
        write_reg(REG_CORRECTION_PERCENT, 31'(c.correction_percent));
        write_reg(REG_SOURCE_RATE, 31'(c.source_rate));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(item_t fr);
        int gap;
        gap = idle_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fr.clock_diff, fr.nominal_samples};
        s_tuser  <= fr.diff_valid;
        do
            @(posedge clk);
        while (!s_tready);
        wanted_q.push_back(predict_wanted_samples(fr));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (wanted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_frames(int count);
        logic [31:0] bias;
        bias = random_drift_bias();
        repeat (count) send_frame(random_frame(bias));
        wait_results_drained();
    endtask

    // register defaults: out-of-range and not-a-number drift, warm-up, clipping both ways
    task automatic test_warmup_and_clip();
        send_frame(make_frame(16'hFFFF, 32'h7FFF_FFFF, 1'b1));
        send_frame(make_frame(16'hFFFF, 32'h8000_0000, 1'b1));
        send_frame(make_frame(16'd0, 32'd0, 1'b0));
        repeat (20) send_frame(make_frame(16'($urandom), HALF_SEC, 1'b1));
        send_frame(make_frame(16'hFFFF, HALF_SEC, 1'b1));
        send_frame(make_frame(16'd0, -HALF_SEC, 1'b1));
        send_frame(make_frame(16'hFFFF, -HALF_SEC, 1'b1));
        wait_results_drained();
    endtask

    // audio master: count passes through and the running sum is left alone
    task automatic test_audio_master();
        cfg_t c;
        c = cfg_model;
        c.sync_to_audio = 1'b1;
        program_config(c);
        send_frame(make_frame(16'hFFFF, HALF_SEC, 1'b1));
        send_frame(make_frame(16'd0, 32'h8000_0000, 1'b1));
        send_frame(make_frame(16'd4800, 32'h7FFF_FFFF, 1'b0));
        send_frame(make_frame(16'd1152, -HALF_SEC, 1'b1));
        wait_results_drained();
        c.sync_to_audio = 1'b0;
        program_config(c);
        send_frame(make_frame(16'd1024, HALF_SEC, 1'b1));
        send_frame(make_frame(16'd1024, -HALF_SEC, 1'b1));
        wait_results_drained();
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        // percent above 100, widest rate, no averaging, zero threshold
        c = '{1'b0, 16'h0000, 31'd0, 31'h7FFF_FFFF, 7'd127, 18'h3FFFF};
        program_config(c);
        run_random_frames(40);
        // zero rate, no room to move, slowest decay, unreachable threshold
        c = '{1'b0, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd0, 18'd0};
        program_config(c);
        run_random_frames(40);
        // zero sync limit: every difference is out of range
        c = '{1'b0, 16'hFFFF, 31'd0, 31'd0, 7'd100, 18'd1};
        program_config(c);
        run_random_frames(40);
        c = '{1'b0, 16'h8000, 31'd1, 31'h1000_0000, 7'd50, 18'd192000};
        program_config(c);
        run_random_frames(40);
    endtask

    task automatic test_random_settings();
        repeat (12) begin
            program_config(random_config());
            run_random_frames(60);
        end
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        cfg_t c;
        c = random_config();
        c.sync_to_audio = 1'b0;
        program_config(c);
        hold_token <= hold_token + 8'd1;
        run_random_frames(50);
    endtask

    task automatic test_back_to_back();
        stall_en = 1'b0;
        program_config(random_config());
        run_random_frames(80);
        stall_en = 1'b1;
    endtask

    // result side: check each transaction and pick the next stall
    always @(posedge clk) begin
        logic [16:0] want;
        if (rst_n && m_tvalid && m_tready) begin
            if (wanted_q.size() == 0) begin
                $error("wanted_samples with no frame pending: actual %0d", m_tdata[16:0]);
                error_count++;
            end
            else begin
                want = wanted_q.pop_front();
                if (m_tdata[16:0] !== want) begin
                    $error("wanted_samples mismatch: expected %0d, actual %0d",
                           want, m_tdata[16:0]);
                    error_count++;
                end
            end
        end
        if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else begin
            m_tready <= 1'b1;
            stall_left = idle_gap();
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("audio_clock_drift_sample_correction verification failed");
            $finish;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_SYNC_TO_AUDIO;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_model.sync_to_audio      = 1'b0;
        cfg_model.avg_coef           = RST_AVG_COEF;
        cfg_model.diff_threshold     = RST_DIFF_THRESHOLD;
        cfg_model.nosync_limit       = RST_NOSYNC_LIMIT;
        cfg_model.correction_percent = RST_CORRECTION_PERCENT;
        cfg_model.source_rate        = RST_SOURCE_RATE;
        pred_drift_sum = 0;
        pred_warmup    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_warmup_and_clip();
        test_audio_master();
        test_config_extremes();
        test_random_settings();
        test_output_backpressure();
        test_back_to_back();

        wait_results_drained();
        if (error_count == 0)
            $display("audio_clock_drift_sample_correction verification clean");
        else
            $display("audio_clock_drift_sample_correction verification failed");
        $finish;
    end

endmodule
